### hdl/tpn_pkg.sv
// Shared types, constants and controller codes for the topic posterior normaliser.
package tpn_pkg;

  // Default number of topics in one vector
  localparam int unsigned TOPICS_DEFAULT = 16;

  // Reciprocal format: Q16.32, 48 bits, one quotient bit per divide step
  localparam int unsigned INV_W     = 48;
  localparam int unsigned STEP_W    = $clog2(INV_W);
  localparam logic [INV_W-1:0] INV_MAX = {INV_W{1'b1}};

  // Sums up to this value give a reciprocal of at least 2^48, so it saturates
  localparam logic [31:0] RECIP_SAT_LIMIT = 32'h0001_0000;
  // Partial remainder before the first quotient bit: 2^64 >> 48
  localparam logic [31:0] REM_INIT = 32'h0001_0000;

  // Status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERO     = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  // One input word
  typedef struct packed {
    logic [15:0] theta_value;
    logic [15:0] phi_value;
    logic        last_element;
  } in_t;

  // One result word
  typedef struct packed {
    logic [31:0]      weight;
    logic [INV_W-1:0] inverse_sum;
    logic             last_result;
    logic [1:0]       status;
  } out_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RECIP_INIT,
    ST_RECIP,
    ST_EMIT,
    ST_DRAIN
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;     // register the accepted word
    logic store;       // multiply, store and accumulate
    logic recip_init;  // set up the divider
    logic recip_step;  // one quotient bit
    logic issue;       // read one stored product into the output pipeline
    logic clear;       // end of run
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_seen;   // captured word carried the last marker
    logic recip_sat;   // reciprocal saturates, no divide needed
    logic recip_done;  // final quotient bit this step
    logic issue_last;  // this issue reads the final stored product
    logic pipe_empty;  // output pipeline holds nothing
  } stat_t;

endpackage

### hdl/tpn_ctrl.sv
// Controller state machine for the topic posterior normaliser.
module tpn_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  tpn_pkg::stat_t stat,
  output tpn_pkg::cmd_t  cmd
);

  tpn_pkg::ctrl_state_t state;
  tpn_pkg::ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tpn_pkg::ST_IDLE: begin
        if (start) state_next = tpn_pkg::ST_LOAD;
      end
      tpn_pkg::ST_LOAD: begin
        state_next = stat.last_seen ? tpn_pkg::ST_RECIP_INIT : tpn_pkg::ST_IDLE;
      end
      tpn_pkg::ST_RECIP_INIT: begin
        state_next = stat.recip_sat ? tpn_pkg::ST_EMIT : tpn_pkg::ST_RECIP;
      end
      tpn_pkg::ST_RECIP: begin
        if (stat.recip_done) state_next = tpn_pkg::ST_EMIT;
      end
      tpn_pkg::ST_EMIT: begin
        if (stat.issue_last) state_next = tpn_pkg::ST_DRAIN;
      end
      tpn_pkg::ST_DRAIN: begin
        if (stat.pipe_empty) state_next = tpn_pkg::ST_IDLE;
      end
      default: state_next = tpn_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      tpn_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      tpn_pkg::ST_LOAD:       cmd.store      = 1'b1;
      tpn_pkg::ST_RECIP_INIT: cmd.recip_init = 1'b1;
      tpn_pkg::ST_RECIP:      cmd.recip_step = 1'b1;
      tpn_pkg::ST_EMIT:       cmd.issue      = 1'b1;
      tpn_pkg::ST_DRAIN:      cmd.clear      = stat.pipe_empty;
      default:                cmd            = '0;
    endcase
  end

endmodule

### hdl/tpn_datapath.sv
// Datapath: product store, sum, bit-serial reciprocal and scaling pipeline.
module tpn_datapath #(
  parameter int unsigned TOPICS = tpn_pkg::TOPICS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  tpn_pkg::in_t   item,
  input  logic           cfg_we,
  input  logic           cfg_data,
  input  tpn_pkg::cmd_t  cmd,
  output tpn_pkg::stat_t stat,
  output logic           result_valid,
  output tpn_pkg::out_t  result
);

  localparam int unsigned ADDR_W = (TOPICS > 1) ? $clog2(TOPICS) : 1;
  localparam int unsigned CNT_W  = $clog2(TOPICS + 1);
  localparam int unsigned SUM_W  = 32 + $clog2(TOPICS);
  localparam int unsigned REM_W  = SUM_W + 1;
  localparam int unsigned INV_W  = tpn_pkg::INV_W;
  localparam int unsigned STEP_W = tpn_pkg::STEP_W;

  // Run state
  logic                normalize_mode;
  tpn_pkg::in_t        in_r;
  logic [SUM_W-1:0]    sum_acc;
  logic [CNT_W-1:0]    elem_count;
  logic                overflow_seen;
  logic [31:0]         product_store [TOPICS];

  // Divider
  logic [REM_W-1:0]    rem;
  logic [INV_W-1:0]    quo;
  logic [STEP_W-1:0]   step_cnt;
  logic [REM_W-1:0]    rem_shift;
  logic                rem_ge;

  // Output pipeline
  logic [ADDR_W-1:0]   emit_idx;
  logic                v1, v2, v3;
  logic                l1, l2;
  logic [31:0]         rd_data;
  logic [31:0]         p2;
  logic [47:0]         mul_hi;
  logic [31:0]         mul_lo_top;
  logic [63:0]         mul_lo;
  logic [48:0]         wsum;
  logic [31:0]         wscaled;
  logic [31:0]         w_sel;
  logic [31:0]         product;
  logic                sum_zero;
  logic [1:0]          run_status;

  assign product  = {16'b0, in_r.theta_value} * {16'b0, in_r.phi_value};
  assign sum_zero = (sum_acc == '0);

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      normalize_mode <= 1'b1;
    end else if (cfg_we) begin
      normalize_mode <= cfg_data;
    end
  end

  // Captured input word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= item;
    end
  end

  // Product store write
  always_ff @(posedge clk) begin
    if (cmd.store && (elem_count < CNT_W'(TOPICS))) begin
      product_store[elem_count[ADDR_W-1:0]] <= product;
    end
  end

  // Sum, count and overflow flag
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      sum_acc       <= '0;
      elem_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.store) begin
      if (elem_count < CNT_W'(TOPICS)) begin
        sum_acc    <= sum_acc + SUM_W'(product);
        elem_count <= elem_count + 1'b1;
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  // Restoring divide of 2^64 by the sum, one quotient bit a cycle
  assign rem_shift = {rem[REM_W-2:0], 1'b0};
  assign rem_ge    = (rem_shift >= {1'b0, sum_acc});

  always_ff @(posedge clk) begin
    if (cmd.recip_init) begin
      rem      <= REM_W'(tpn_pkg::REM_INIT);
      step_cnt <= STEP_W'(INV_W - 1);
      quo      <= (sum_acc <= SUM_W'(tpn_pkg::RECIP_SAT_LIMIT)) ? tpn_pkg::INV_MAX : '0;
    end else if (cmd.recip_step) begin
      rem      <= rem_ge ? (rem_shift - {1'b0, sum_acc}) : rem_shift;
      quo      <= {quo[INV_W-2:0], rem_ge};
      step_cnt <= step_cnt - 1'b1;
    end
  end

  // Emit index
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      emit_idx <= '0;
    end else if (cmd.issue) begin
      emit_idx <= emit_idx + 1'b1;
    end
  end

  // Pipeline valid and last flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage 1: registered store read
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data <= product_store[emit_idx];
    end
    l1 <= stat.issue_last;
  end

  // Stage 2: partial products against the reciprocal
  assign mul_lo = 64'(rd_data) * 64'(quo[31:0]);

  always_ff @(posedge clk) begin
    mul_hi     <= 48'(rd_data) * 48'(quo[INV_W-1:32]);
    mul_lo_top <= mul_lo[63:32];
    p2         <= rd_data;
    l2         <= l1;
  end

  // Stage 3: sum, saturate and select
  assign wsum    = 49'(mul_hi) + 49'(mul_lo_top);
  assign wscaled = (wsum[48:32] != '0) ? 32'hFFFF_FFFF : wsum[31:0];

  always_comb begin
    if (sum_zero) begin
      w_sel = '0;
    end else if (normalize_mode) begin
      w_sel = wscaled;
    end else begin
      w_sel = p2;
    end
  end

  always_comb begin
    if (overflow_seen) begin
      run_status = tpn_pkg::STATUS_OVERFLOW;
    end else if (sum_zero) begin
      run_status = tpn_pkg::STATUS_ZERO;
    end else begin
      run_status = tpn_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    result.weight      <= w_sel;
    result.inverse_sum <= quo;
    result.last_result <= l2;
    result.status      <= run_status;
  end

  assign result_valid = v3;

  // Status to the controller
  assign stat.last_seen  = in_r.last_element;
  assign stat.recip_sat  = (sum_acc <= SUM_W'(tpn_pkg::RECIP_SAT_LIMIT));
  assign stat.recip_done = (step_cnt == '0);
  assign stat.issue_last = ((CNT_W'(emit_idx) + 1'b1) == elem_count);
  assign stat.pipe_empty = !(v1 || v2 || v3);

endmodule

### hdl/topic_posterior_normalizer_core.sv
// Top level of the topic posterior normaliser: controller plus datapath.
//
// Usage: one topic element (theta, phi, last marker) is offered on item with
// start; it is taken at a clock edge where start is high and busy is low.
// An element that is not last is captured, then multiplied, stored and
// accumulated. Up to TOPICS elements are stored; further ones are
// dropped and flag status 2 for the run, but a dropped last element still
// ends it.
// On the last element the reciprocal of the sum is formed by a restoring
// divider producing one quotient bit a cycle: a set-up step, then 48 steps,
// skipped when the sum is 2^16 or below (reciprocal saturates). The stored
// products are then read one a cycle through a 3-stage scaling pipeline;
// the results follow one a cycle. busy stays high after the final result
// while the run is cleared, then drops.
// Results are on result for one cycle with result_valid high; the receiver
// cannot stall them. normalize_mode is to be written through
// cfg_we/cfg_data only while busy is low; the block itself does not
// enforce this. Synchronous reset returns to idle, clears the run and
// sets normalize mode; no stored product needs clearing.
module topic_posterior_normalizer_core #(
  parameter int unsigned TOPICS = tpn_pkg::TOPICS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  tpn_pkg::in_t  item,
  input  logic          cfg_we,
  input  logic          cfg_data,
  output logic          result_valid,
  output tpn_pkg::out_t result
);

  tpn_pkg::cmd_t  cmd;
  tpn_pkg::stat_t stat;

  tpn_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  tpn_datapath #(
    .TOPICS (TOPICS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

### hdl/tpn_checker.sv
// Port-level checker for the topic posterior normaliser, bound to the top level.
module tpn_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          result_valid,
  input tpn_pkg::out_t result
);

  // A result word only while a run is in progress
  a_result_in_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result word outside a run");

  // An accepted word makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("not busy after accepting a word");

  // Reset leaves the block idle and silent
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !result_valid))
    else $error("not idle after reset");

  // Nothing follows the final word of a run
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last_result) |=> !result_valid)
    else $error("result word after the final one");

  // Zero sum gives zero weights
  a_zero_sum_weight: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status == tpn_pkg::STATUS_ZERO)) |-> (result.weight == '0))
    else $error("non-zero weight with zero sum");

endmodule

bind topic_posterior_normalizer_core tpn_checker u_tpn_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);
